// ===== src/websocket_frame_deframer_assert.svh =====
// Assertion macros used by the deframer parser (wsd_parse).
`ifndef WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication.
`define WSD_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define WSD_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);
`else
`define WSD_ASSERT_IMP(lbl, ck, rn, ante, cons, msg)
`define WSD_ASSERT_NXT(lbl, ck, rn, ante, cons, msg)
`endif

`endif

// ===== src/wsd_pkg.sv =====
package wsd_pkg;

  localparam logic [6:0]  LEN_IS_16          = 7'd126;
  localparam logic [6:0]  LEN_IS_64          = 7'd127;
  localparam logic [31:0] DEFAULT_MAX_MASKED = 32'd1048576;

  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  typedef enum logic [2:0] {
    PH_FIRST   = 3'd0,
    PH_SECOND  = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_KEY     = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    ACT_MESSAGE = 3'd0,
    ACT_CLOSE   = 3'd1,
    ACT_PING    = 3'd2,
    ACT_PONG    = 3'd3,
    ACT_UNKNOWN = 3'd4,
    ACT_TOO_BIG = 3'd5
  } action_t;

  typedef struct packed {
    logic        valid;
    logic [7:0]  rx_byte;
  } item_t;

  typedef struct packed {
    logic        data_valid;
    logic [7:0]  payload_byte;
    logic        frame_end;
    action_t     action;
    logic [3:0]  frame_opcode;
    logic [63:0] frame_length;
  } result_t;

endpackage

// ===== src/websocket_frame_deframer.sv =====
// Path: an accepted input item is held in the input register, then decoded
// into the result register. Throughput: one byte per cycle unless stalled;
// header bytes give a result item only at an empty frame's end or a too-big length.
// Reset: synchronous, active-low rst_n; resets the frame phase and clears the halt,
// and loads max_len_r with 1048576.
module websocket_frame_deframer
  import wsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_data_valid,
  output logic [7:0]  out_payload_byte,
  output logic        out_frame_end,
  output logic [2:0]  out_action,
  output logic [3:0]  out_frame_opcode,
  output logic [63:0] out_frame_length
);

  item_t   item;
  logic    take;
  logic    adv;
  logic    res_valid;
  result_t res;
  result_t out_res;

  wsd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .take_i     (take),
    .item_o     (item)
  );

  wsd_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item_i      (item),
    .adv_i       (adv),
    .take_o      (take),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  wsd_out_reg u_out_reg (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid_i (res_valid),
    .res_i       (res),
    .adv_o       (adv),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_o       (out_res)
  );

  assign out_data_valid   = out_res.data_valid;
  assign out_payload_byte = out_res.payload_byte;
  assign out_frame_end    = out_res.frame_end;
  assign out_action       = out_res.action;
  assign out_frame_opcode = out_res.frame_opcode;
  assign out_frame_length = out_res.frame_length;

endmodule

// ===== src/wsd_in_reg.sv =====
module wsd_in_reg
  import wsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       take_i,
  output item_t      item_o
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;
  logic       load;

  // Hold an item until the parser takes it
  assign in_stall  = valid_r && !take_i;
  assign load      = in_valid && !in_stall;
  assign valid_nxt = load || (valid_r && !take_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= in_rx_byte;
    end
  end

  assign item_o.valid   = valid_r;
  assign item_o.rx_byte = byte_r;

endmodule

// ===== src/wsd_parse.sv =====
`include "websocket_frame_deframer_assert.svh"

module wsd_parse
  import wsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  item_t       item_i,
  input  logic        adv_i,
  output logic        take_o,
  output logic        res_valid_o,
  output result_t     res_o
);

  logic [31:0] max_len_r;
  phase_t      phase_r, phase_nxt;
  logic [3:0]  opcode_r, opcode_nxt;
  logic        mask_r, mask_nxt;
  logic [63:0] accum_r, accum_nxt;
  logic [63:0] left_r, left_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [31:0] key_r, key_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic        halted_r, halted_nxt;
  logic        fire;

  assign fire   = item_i.valid && adv_i;
  assign take_o = fire;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= DEFAULT_MAX_MASKED;
    end else if (cfg_wr_en) begin
      max_len_r <= cfg_wr_data;
    end
  end

  // Decode one byte against the frame state
  always_comb begin
    logic [7:0]  b;
    logic [6:0]  len7;
    logic [63:0] acc;
    logic [63:0] ld_len;
    logic [7:0]  kb;
    logic        ld;
    logic        fd;
    b          = item_i.rx_byte;
    len7       = b[6:0];
    acc        = {accum_r[55:0], b};
    ld_len     = '0;
    kb         = '0;
    ld         = 1'b0;
    fd         = 1'b0;
    phase_nxt  = phase_r;
    opcode_nxt = opcode_r;
    mask_nxt   = mask_r;
    accum_nxt  = accum_r;
    left_nxt   = left_r;
    cnt_nxt    = cnt_r;
    key_nxt    = key_r;
    idx_nxt    = idx_r;
    halted_nxt = halted_r;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (fire && !halted_r) begin
      unique case (phase_r)
        PH_SECOND: begin
          mask_nxt = b[7];
          if (len7 == LEN_IS_16 || len7 == LEN_IS_64) begin
            accum_nxt = '0;
            // a count of eight wraps to zero in three bits
            cnt_nxt   = (len7 == LEN_IS_16) ? 3'd2 : 3'd0;
            phase_nxt = PH_EXTLEN;
          end else begin
            ld     = 1'b1;
            ld_len = {57'd0, len7};
          end
        end
        PH_EXTLEN: begin
          accum_nxt = acc;
          cnt_nxt   = cnt_r - 3'd1;
          if (cnt_r == 3'd1) begin
            ld     = 1'b1;
            ld_len = acc;
          end
        end
        PH_KEY: begin
          key_nxt = {key_r[23:0], b};
          cnt_nxt = cnt_r - 3'd1;
          if (cnt_r == 3'd1) begin
            idx_nxt = 2'd0;
            if (left_r == 64'd0) begin
              fd = 1'b1;
            end else begin
              phase_nxt = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          if (mask_r) begin
            unique case (idx_r)
              2'd0: kb = key_r[31:24];
              2'd1: kb = key_r[23:16];
              2'd2: kb = key_r[15:8];
              default: kb = key_r[7:0];
            endcase
          end
          res_valid_o        = 1'b1;
          res_o.data_valid   = 1'b1;
          res_o.payload_byte = b ^ kb;
          idx_nxt  = idx_r + 2'd1;
          left_nxt = left_r - 64'd1;
          if (left_r == 64'd1) begin
            fd = 1'b1;
          end
        end
        default: begin
          opcode_nxt = b[3:0];
          phase_nxt  = PH_SECOND;
        end
      endcase

      // Length complete: check the limit if masked, then key, payload or empty frame
      if (ld) begin
        accum_nxt = ld_len;
        left_nxt  = ld_len;
        idx_nxt   = 2'd0;
        if (mask_nxt) begin
          if (ld_len > {32'd0, max_len_r}) begin
            res_valid_o        = 1'b1;
            res_o.frame_end    = 1'b1;
            res_o.action       = ACT_TOO_BIG;
            res_o.frame_opcode = opcode_r;
            res_o.frame_length = ld_len;
            halted_nxt = 1'b1;
            phase_nxt  = PH_FIRST;
          end else begin
            key_nxt   = '0;
            cnt_nxt   = 3'd4;
            phase_nxt = PH_KEY;
          end
        end else if (ld_len == 64'd0) begin
          fd = 1'b1;
        end else begin
          phase_nxt = PH_PAYLOAD;
        end
      end

      // Frame end: report the opcode action; close and unknown opcodes halt
      if (fd) begin
        res_valid_o        = 1'b1;
        res_o.frame_end    = 1'b1;
        res_o.frame_opcode = opcode_r;
        res_o.frame_length = accum_nxt;
        phase_nxt          = PH_FIRST;
        priority case (opcode_r)
          OP_TEXT, OP_BINARY: res_o.action = ACT_MESSAGE;
          OP_CLOSE: begin
            res_o.action = ACT_CLOSE;
            halted_nxt   = 1'b1;
          end
          OP_PING: res_o.action = ACT_PING;
          OP_PONG: res_o.action = ACT_PONG;
          default: begin
            res_o.action = ACT_UNKNOWN;
            halted_nxt   = 1'b1;
          end
        endcase
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_FIRST;
      halted_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      halted_r <= halted_nxt;
    end
  end

  // Frame context
  always_ff @(posedge clk) begin
    opcode_r <= opcode_nxt;
    mask_r   <= mask_nxt;
    accum_r  <= accum_nxt;
    left_r   <= left_nxt;
    cnt_r    <= cnt_nxt;
    key_r    <= key_nxt;
    idx_r    <= idx_nxt;
  end

  `WSD_ASSERT_NXT(a_halt_sticky, clk, rst_n, halted_r, halted_r, "halt was released")
  `WSD_ASSERT_IMP(a_halt_silent, clk, rst_n, halted_r, !res_valid_o, "result while halted")
  `WSD_ASSERT_IMP(a_payload_left, clk, rst_n, phase_r == PH_PAYLOAD, left_r != 64'd0,
                  "payload phase with no bytes left")
  `WSD_ASSERT_NXT(a_fatal_halts, clk, rst_n,
                  res_valid_o && res_o.frame_end &&
                  (res_o.action == ACT_CLOSE || res_o.action == ACT_UNKNOWN ||
                   res_o.action == ACT_TOO_BIG),
                  halted_r, "fatal report did not halt")

endmodule

// ===== src/wsd_out_reg.sv =====
module wsd_out_reg
  import wsd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    res_valid_i,
  input  result_t res_i,
  output logic    adv_o,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_o
);

  logic    valid_r;
  result_t res_r;

  // Free when empty or being taken this cycle
  assign adv_o = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv_o) begin
      valid_r <= res_valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_o && res_valid_i) begin
      res_r <= res_i;
    end
  end

  assign out_valid = valid_r;
  assign out_o     = res_r;

endmodule

// ===== dv/tb_websocket_frame_deframer.sv =====
`timescale 1ns / 100ps

module tb_websocket_frame_deframer;
  import wsd_pkg::*;

  // Predicts deframer results byte by byte and holds them until they come out.
  class deframe_scoreboard;
    logic [31:0] size_limit;
    phase_t      step;
    logic [3:0]  op_held;
    logic        masked;
    logic [63:0] len_acc;
    logic [63:0] remaining;
    int unsigned hdr_left;
    logic [31:0] key;
    logic [1:0]  key_pos;
    logic        stopped;
    result_t     expected_q[$];
    int unsigned mismatches;

    function new();
      size_limit = DEFAULT_MAX_MASKED;
      step       = PH_FIRST;
      op_held    = '0;
      masked     = 1'b0;
      len_acc    = '0;
      remaining  = '0;
      hdr_left   = 0;
      key        = '0;
      key_pos    = '0;
      stopped    = 1'b0;
      mismatches = 0;
    endfunction

    function action_t opcode_action(logic [3:0] op);
      case (op)
        OP_TEXT, OP_BINARY: return ACT_MESSAGE;
        OP_CLOSE:           return ACT_CLOSE;
        OP_PING:            return ACT_PING;
        OP_PONG:            return ACT_PONG;
        default:            return ACT_UNKNOWN;
      endcase
    endfunction

    // Fill in the end-of-frame report; close and unknown opcodes stop the block
    function void finish_frame(inout result_t r);
      r.frame_end    = 1'b1;
      r.action       = opcode_action(op_held);
      r.frame_opcode = op_held;
      r.frame_length = len_acc;
      if (r.action inside {ACT_CLOSE, ACT_UNKNOWN}) stopped = 1'b1;
      step = PH_FIRST;
    endfunction

    // Length is known: check the masked limit, then go to key or payload, or end an empty frame
    function bit length_complete(logic [63:0] n, inout result_t r);
      len_acc   = n;
      remaining = n;
      key_pos   = '0;
      if (masked) begin
        if (n > {32'd0, size_limit}) begin
          r.frame_end    = 1'b1;
          r.action       = ACT_TOO_BIG;
          r.frame_opcode = op_held;
          r.frame_length = n;
          stopped        = 1'b1;
          step           = PH_FIRST;
          return 1'b1;
        end
        key      = '0;
        hdr_left = 4;
        step     = PH_KEY;
        return 1'b0;
      end
      if (n == 64'd0) begin
        finish_frame(r);
        return 1'b1;
      end
      step = PH_PAYLOAD;
      return 1'b0;
    endfunction

    // Advance the frame state by one accepted byte
    function void deframe_byte(logic [7:0] b);
      result_t    r;
      bit         produced;
      logic [7:0] kb;
      r        = '0;
      produced = 1'b0;
      if (stopped) return;
      case (step)
        PH_SECOND: begin
          masked = b[7];
          if (b[6:0] == LEN_IS_16 || b[6:0] == LEN_IS_64) begin
            len_acc  = '0;
            hdr_left = (b[6:0] == LEN_IS_16) ? 2 : 8;
            step     = PH_EXTLEN;
          end else begin
            produced = length_complete({57'd0, b[6:0]}, r);
          end
        end
        PH_EXTLEN: begin
          len_acc  = {len_acc[55:0], b};
          hdr_left = hdr_left - 1;
          if (hdr_left == 0) produced = length_complete(len_acc, r);
        end
        PH_KEY: begin
          key      = {key[23:0], b};
          hdr_left = hdr_left - 1;
          if (hdr_left == 0) begin
            key_pos = '0;
            if (remaining == 64'd0) begin
              finish_frame(r);
              produced = 1'b1;
            end else begin
              step = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          kb             = masked ? key[8 * (3 - int'(key_pos)) +: 8] : 8'h00;
          r.data_valid   = 1'b1;
          r.payload_byte = b ^ kb;
          key_pos        = key_pos + 2'd1;
          remaining      = remaining - 64'd1;
          if (remaining == 64'd0) finish_frame(r);
          produced = 1'b1;
        end
        default: begin
          op_held = b[3:0];
          step    = PH_SECOND;
        end
      endcase
      if (produced) expected_q.push_back(r);
    endfunction

    task report_mismatch(string msg);
      if (mismatches < 100) $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    // Compare one output item against the oldest prediction
    task check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected output item %p", got));
        return;
      end
      want = expected_q.pop_front();
      if (got.data_valid !== want.data_valid)
        report_mismatch($sformatf("data_valid exp %0b got %0b",
                                  want.data_valid, got.data_valid));
      if (got.payload_byte !== want.payload_byte)
        report_mismatch($sformatf("payload_byte exp %02h got %02h",
                                  want.payload_byte, got.payload_byte));
      if (got.frame_end !== want.frame_end)
        report_mismatch($sformatf("frame_end exp %0b got %0b",
                                  want.frame_end, got.frame_end));
      if (got.action !== want.action)
        report_mismatch($sformatf("action exp %0d got %0d", want.action, got.action));
      if (got.frame_opcode !== want.frame_opcode)
        report_mismatch($sformatf("frame_opcode exp %h got %h",
                                  want.frame_opcode, got.frame_opcode));
      if (got.frame_length !== want.frame_length)
        report_mismatch($sformatf("frame_length exp %016h got %016h",
                                  want.frame_length, got.frame_length));
    endtask
  endclass

  typedef enum int {LEN_MIN, LEN_16, LEN_64} len_form_t;

  localparam int unsigned STREAM_BYTES = 1730;

  logic        clk              = 1'b0;
  logic        rst_n            = 1'b0;
  logic        cfg_wr_en        = 1'b0;
  logic [31:0] cfg_wr_data      = '0;
  logic        in_valid         = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte       = '0;
  logic        out_valid;
  logic        out_stall        = 1'b0;
  logic        out_data_valid;
  logic [7:0]  out_payload_byte;
  logic        out_frame_end;
  logic [2:0]  out_action;
  logic [3:0]  out_frame_opcode;
  logic [63:0] out_frame_length;

  deframe_scoreboard sb = new();

  logic [31:0] limit_now   = DEFAULT_MAX_MASKED;
  int unsigned bytes_sent  = 0;
  int          gap_style   = 1;
  int          stall_style = 1;
  int unsigned stall_run   = 0;

  websocket_frame_deframer u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data_valid   (out_data_valid),
    .out_payload_byte (out_payload_byte),
    .out_frame_end    (out_frame_end),
    .out_action       (out_action),
    .out_frame_opcode (out_frame_opcode),
    .out_frame_length (out_frame_length)
  );

  always #5 clk = ~clk;

  // Drive output backpressure: short flickers, occasional long holds
  always @(negedge clk) begin
    int unsigned roll;
    if (!rst_n || stall_style == 0) begin
      out_stall <= 1'b0;
      stall_run <= 0;
    end else if (stall_run > 0) begin
      stall_run <= stall_run - 1;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
        out_stall <= 1'b0;
        stall_run <= $urandom_range(0, 3);
      end else if (roll < 92) begin
        out_stall <= 1'b1;
        stall_run <= $urandom_range(0, 2);
      end else begin
        out_stall <= 1'b1;
        stall_run <= $urandom_range(8, 30);
      end
    end
  end

  // Check every output item taken at a rising edge
  always @(posedge clk) begin
    result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.data_valid   = out_data_valid;
      got.payload_byte = out_payload_byte;
      got.frame_end    = out_frame_end;
      got.action       = action_t'(out_action);
      got.frame_opcode = out_frame_opcode;
      got.frame_length = out_frame_length;
      sb.check_result(got);
    end
  end

  // Offer one byte, hold it until taken, then predict its effect
  task automatic push_byte(input logic [7:0] b);
    int unsigned idle;
    int unsigned roll;
    idle = 0;
    if (gap_style != 0) begin
      roll = $urandom_range(0, 99);
      if (roll >= 92) idle = $urandom_range(8, 30);
      else if (roll >= 60) idle = $urandom_range(1, 3);
    end
    @(negedge clk);
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    sb.deframe_byte(b);
    bytes_sent++;
  endtask

  // Drop valid and wait for the block to empty out
  task automatic settle();
    @(negedge clk) in_valid <= 1'b0;
    for (int w = 0; w < 5000 && sb.expected_q.size() != 0; w++) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [31:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    sb.size_limit = v;
    limit_now     = v;
    @(negedge clk) cfg_wr_en <= 1'b0;
  endtask

  // Send header, key and payload of one frame; stop after the header if too big
  task automatic send_frame(input logic [7:0] first, input logic mask_on,
                            input logic [63:0] len, input len_form_t form,
                            input logic [31:0] k);
    len_form_t f;
    f = form;
    if (len > 64'd65535) f = LEN_64;
    else if (f == LEN_MIN && len > 64'd125) f = LEN_16;
    push_byte(first);
    case (f)
      LEN_MIN: push_byte({mask_on, len[6:0]});
      LEN_16: begin
        push_byte({mask_on, LEN_IS_16});
        push_byte(len[15:8]);
        push_byte(len[7:0]);
      end
      default: begin
        push_byte({mask_on, LEN_IS_64});
        for (int i = 7; i >= 0; i--) push_byte(len[8 * i +: 8]);
      end
    endcase
    if (mask_on && len > {32'd0, limit_now}) return;
    if (mask_on) for (int i = 3; i >= 0; i--) push_byte(k[8 * i +: 8]);
    for (longint unsigned n = 0; n < len; n++) push_byte(8'($urandom));
  endtask

  function automatic logic [3:0] good_opcode();
    case ($urandom_range(0, 3))
      0:       return OP_TEXT;
      1:       return OP_BINARY;
      2:       return OP_PING;
      default: return OP_PONG;
    endcase
  endfunction

  // Random well-formed frame that stays within the masked limit
  task automatic send_random_frame();
    logic [63:0] len;
    logic        mask_on;
    len_form_t   form;
    int unsigned roll;
    mask_on = 1'($urandom_range(0, 1));
    roll    = $urandom_range(0, 99);
    if (roll < 10) len = '0;
    else if (roll < 75) len = 64'($urandom_range(1, 20));
    else if (roll < 95) len = 64'($urandom_range(21, 60));
    else len = 64'($urandom_range(100, 140));
    if (mask_on && len > {32'd0, limit_now}) len = {32'd0, limit_now};
    roll = $urandom_range(0, 99);
    form = (roll < 70) ? LEN_MIN : (roll < 85) ? LEN_16 : LEN_64;
    send_frame({4'($urandom), good_opcode()}, mask_on, len, form, $urandom);
  endtask

  initial begin
    int          phase_no;
    int          end_kind;
    logic [3:0]  bad_op;
    logic [31:0] lim;

    repeat (10) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed: empty frame, masked at the limit, empty masked, unmasked over the limit
    write_limit(32'd3);
    send_frame({4'hF, OP_TEXT}, 1'b0, 64'd0, LEN_MIN, 32'h0);
    send_frame({4'h8, OP_BINARY}, 1'b1, 64'd3, LEN_16, 32'hA500_FF3C);
    send_frame({4'h0, OP_PONG}, 1'b1, 64'd0, LEN_MIN, 32'hFFFF_FFFF);
    send_frame({4'h8, OP_PING}, 1'b0, 64'd5, LEN_64, 32'h0);

    // Random phases, each with its own limit and idle pattern
    phase_no = 0;
    while (bytes_sent < STREAM_BYTES) begin
      settle();
      case (phase_no % 5)
        0:       lim = DEFAULT_MAX_MASKED;
        1:       lim = 32'd0;
        2:       lim = 32'hFFFF_FFFF;
        3:       lim = $urandom_range(0, 160);
        default: lim = $urandom;
      endcase
      write_limit(lim);
      gap_style   = ($urandom_range(0, 3) == 0) ? 0 : 1;
      stall_style = ($urandom_range(0, 3) == 0) ? 0 : 1;
      repeat ($urandom_range(4, 12)) send_random_frame();
      phase_no++;
    end

    // Finish with one stopping frame, then bytes that must be ignored
    end_kind = $urandom_range(0, 3);
    case (end_kind)
      0: send_frame({4'($urandom), OP_CLOSE}, 1'b0, 64'($urandom_range(0, 6)),
                    LEN_MIN, $urandom);
      1: begin
        do bad_op = 4'($urandom); while (bad_op inside
          {OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG});
        send_frame({4'($urandom), bad_op}, 1'b0, 64'($urandom_range(0, 6)),
                   LEN_MIN, $urandom);
      end
      2: begin
        settle();
        write_limit($urandom_range(0, 200));
        send_frame({4'($urandom), good_opcode()}, 1'b1, {32'd0, limit_now} + 64'd1,
                   LEN_MIN, $urandom);
      end
      default: begin
        settle();
        write_limit(32'hFFFF_FFFF);
        send_frame({4'($urandom), good_opcode()}, 1'b1,
                   {1'b1, 31'($urandom), 32'($urandom)}, LEN_64, $urandom);
      end
    endcase
    repeat (12) push_byte(8'($urandom));

    settle();
    if (sb.expected_q.size() != 0)
      sb.report_mismatch($sformatf("%0d output items never arrived", sb.expected_q.size()));
    if (sb.mismatches == 0) begin
      $display("websocket_frame_deframer verification clean");
    end else begin
      $display("websocket_frame_deframer verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #8000000;
    $display("websocket_frame_deframer verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/wsd_pkg.sv
src/wsd_in_reg.sv
src/wsd_parse.sv
src/wsd_out_reg.sv
src/websocket_frame_deframer.sv
dv/tb_websocket_frame_deframer.sv
